// ===== rtl/irt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package irt_pkg;

	localparam int ENTRIES   = 16;
	localparam int PEER_BITS = 16;
	localparam int IDX_W     = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W     = $clog2(ENTRIES + 1);

	localparam int TYPE_W    = 32;
	localparam int HASH_W    = 64;
	localparam int PEER_W    = 16;
	localparam int TIME_W    = 32;
	localparam int OCC_W     = 5;
	localparam int TMO_W     = 16;

	localparam int S_TDATA_W = 336;
	localparam int M_TDATA_W = 312;
	localparam int APB_AW    = 3;

	localparam logic [TMO_W-1:0] TMO_RESET = 16'd60;
	localparam logic REG_TIMEOUT = 1'b0;

	typedef enum logic [1:0] {
		CMD_INSERT = 2'd0,
		CMD_LOOKUP = 2'd1,
		CMD_REMOVE = 2'd2,
		CMD_SCAN   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2,
		ST_NONE = 2'd3
	} status_t;

	typedef struct packed {
		logic load_in;
		logic eval;
		logic emit_op;
		logic emit_scan;
	} ctl_t;

	typedef struct packed {
		logic scan_cmd;
		logic scan_empty;
		logic scan_last;
		logic out_free;
	} sts_t;

endpackage
`default_nettype wire

// ===== rtl/irt_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module irt_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  irt_pkg::sts_t      sts,
	output irt_pkg::ctl_t      ctl
);
	import irt_pkg::*;

	typedef enum logic [1:0] {
		S_IDLE,
		S_EVAL,
		S_RUN
	} state_t;

	state_t state_q, state_d;
	logic   ready_q;

	assign s_tready = ready_q;

	always_comb begin
		ctl = '0;
		ctl.load_in = ready_q & s_tvalid;
		ctl.eval = (state_q == S_EVAL);
		if (state_q == S_RUN && sts.out_free) begin
			if (!sts.scan_cmd || sts.scan_empty) begin
				ctl.emit_op = 1'b1;
			end else begin
				ctl.emit_scan = 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (ctl.load_in) state_d = S_EVAL;
			end
			S_EVAL: begin
				state_d = S_RUN;
			end
			S_RUN: begin
				if (ctl.emit_op || (ctl.emit_scan && sts.scan_last)) state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b0;
		end else begin
			state_q <= state_d;
			ready_q <= (state_d == S_IDLE);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({ctl.emit_op, ctl.emit_scan}))
		else $error("single result and scan result emitted together");

	assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (state_q == S_EVAL && !s_tready))
		else $error("accepted word did not start evaluation");

endmodule
`default_nettype wire

// ===== rtl/irt_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
module irt_dpath (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// s_tdata: key_type, key_hash_w0..w3, peer_in, time_now (lowest bit up)
	input  wire logic [irt_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: command
	input  wire logic [1:0]                      s_tuser,
	input  wire logic [irt_pkg::TMO_W-1:0]       timeout,
	input  irt_pkg::ctl_t                        ctl,
	output irt_pkg::sts_t                        sts,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata: peer_out, out_key_type, out_hash_w0..w3, occupancy, zero pad
	output logic [irt_pkg::M_TDATA_W-1:0]        m_tdata,
	// m_tuser: status
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);
	import irt_pkg::*;

	// latched input word
	cmd_t               cmd_q;
	logic [TYPE_W-1:0]  type_q;
	logic [HASH_W-1:0]  h0_q, h1_q, h2_q, h3_q;
	logic [PEER_W-1:0]  peer_q;
	logic [TIME_W-1:0]  now_q;

	// table
	logic [ENTRIES-1:0]   ent_valid_q;
	logic [TYPE_W-1:0]    ent_type_q  [ENTRIES];
	logic [HASH_W-1:0]    ent_h0_q    [ENTRIES];
	logic [HASH_W-1:0]    ent_h1_q    [ENTRIES];
	logic [HASH_W-1:0]    ent_h2_q    [ENTRIES];
	logic [HASH_W-1:0]    ent_h3_q    [ENTRIES];
	logic [PEER_BITS-1:0] ent_peer_q  [ENTRIES];
	logic [TIME_W-1:0]    ent_stamp_q [ENTRIES];
	logic [CNT_W-1:0]     count_q, count_d;

	// evaluation results
	logic [ENTRIES-1:0] hit_d, exp_d, hit_q, pend_q;
	logic [TIME_W-1:0]  age_d [ENTRIES];
	logic [IDX_W-1:0]   hit_idx_d, hit_idx_q, free_idx_d, free_idx_q;
	logic               full_d, full_q, hit_any;

	logic [ENTRIES-1:0] pend_low, pend_rest;
	logic [IDX_W-1:0]   scan_idx, rd_idx;
	logic               ins_ok, rem_ok, out_free;

	// output register
	logic                m_valid_q;
	status_t             m_status_q;
	logic [PEER_W-1:0]   m_peer_q;
	logic [TYPE_W-1:0]   m_type_q;
	logic [HASH_W-1:0]   m_h0_q, m_h1_q, m_h2_q, m_h3_q;
	logic                m_last_q;
	logic [OCC_W-1:0]    m_occ_q;

	always_ff @(posedge clk) begin
		if (ctl.load_in) begin
			cmd_q  <= cmd_t'(s_tuser);
			type_q <= s_tdata[31:0];
			h0_q   <= s_tdata[95:32];
			h1_q   <= s_tdata[159:96];
			h2_q   <= s_tdata[223:160];
			h3_q   <= s_tdata[287:224];
			peer_q <= s_tdata[303:288];
			now_q  <= s_tdata[335:304];
		end
	end

	// parallel key compare and age check over all slots
	always_comb begin
		hit_idx_d  = '0;
		free_idx_d = '0;
		full_d     = 1'b1;
		for (int i = 0; i < ENTRIES; i++) begin
			age_d[i] = now_q - ent_stamp_q[i];
			hit_d[i] = ent_valid_q[i] && ent_type_q[i] == type_q &&
				ent_h0_q[i] == h0_q && ent_h1_q[i] == h1_q &&
				ent_h2_q[i] == h2_q && ent_h3_q[i] == h3_q;
			exp_d[i] = ent_valid_q[i] && (age_d[i] >= {16'b0, timeout});
			if (hit_d[i]) hit_idx_d = hit_idx_d | IDX_W'(i);
		end
		// lowest free slot wins
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (!ent_valid_q[i]) begin
				free_idx_d = IDX_W'(i);
				full_d     = 1'b0;
			end
		end
	end

	assign hit_any   = |hit_q;
	assign pend_low  = pend_q & (~pend_q + 1'b1);
	assign pend_rest = pend_q & ~pend_low;

	always_comb begin
		scan_idx = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (pend_low[i]) scan_idx = scan_idx | IDX_W'(i);
		end
	end

	assign rd_idx = ctl.emit_scan ? scan_idx : hit_idx_q;
	assign ins_ok = (cmd_q == CMD_INSERT) && !hit_any && !full_q;
	assign rem_ok = (cmd_q == CMD_REMOVE) && hit_any;

	always_comb begin
		count_d = count_q;
		if (ctl.emit_op && ins_ok) begin
			count_d = count_q + 1'b1;
		end else if (ctl.emit_op && rem_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= '0;
			pend_q      <= '0;
			ent_valid_q <= '0;
			count_q     <= '0;
		end else begin
			if (ctl.eval) begin
				hit_q  <= hit_d;
				pend_q <= exp_d;
			end else if (ctl.emit_scan) begin
				pend_q <= pend_rest;
			end
			if (ctl.emit_op && ins_ok) ent_valid_q[free_idx_q] <= 1'b1;
			if (ctl.emit_op && rem_ok) ent_valid_q[hit_idx_q] <= 1'b0;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.eval) begin
			hit_idx_q  <= hit_idx_d;
			free_idx_q <= free_idx_d;
			full_q     <= full_d;
		end
		if (ctl.emit_op && ins_ok) begin
			ent_type_q[free_idx_q]  <= type_q;
			ent_h0_q[free_idx_q]    <= h0_q;
			ent_h1_q[free_idx_q]    <= h1_q;
			ent_h2_q[free_idx_q]    <= h2_q;
			ent_h3_q[free_idx_q]    <= h3_q;
			ent_peer_q[free_idx_q]  <= PEER_BITS'(peer_q);
			ent_stamp_q[free_idx_q] <= now_q;
		end
	end

	// output register
	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (ctl.emit_op || ctl.emit_scan) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.emit_scan) begin
			m_status_q <= ST_OK;
			m_peer_q   <= PEER_W'(ent_peer_q[rd_idx]);
			m_type_q   <= ent_type_q[rd_idx];
			m_h0_q     <= ent_h0_q[rd_idx];
			m_h1_q     <= ent_h1_q[rd_idx];
			m_h2_q     <= ent_h2_q[rd_idx];
			m_h3_q     <= ent_h3_q[rd_idx];
			m_last_q   <= (pend_rest == '0);
			m_occ_q    <= OCC_W'(count_q);
		end else if (ctl.emit_op) begin
			m_peer_q <= '0;
			case (cmd_q) inside
				CMD_INSERT: begin
					m_status_q <= hit_any ? ST_MISS : (full_q ? ST_FULL : ST_OK);
				end
				CMD_LOOKUP, CMD_REMOVE: begin
					m_status_q <= hit_any ? ST_OK : ST_MISS;
					if (hit_any) m_peer_q <= PEER_W'(ent_peer_q[rd_idx]);
				end
				default: begin
					m_status_q <= ST_NONE;
				end
			endcase
			m_type_q <= '0;
			m_h0_q   <= '0;
			m_h1_q   <= '0;
			m_h2_q   <= '0;
			m_h3_q   <= '0;
			m_last_q <= 1'b1;
			m_occ_q  <= OCC_W'(count_d);
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_status_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = {3'b000, m_occ_q, m_h3_q, m_h2_q, m_h1_q, m_h0_q, m_type_q, m_peer_q};

	always_comb begin
		sts.scan_cmd   = (cmd_q == CMD_SCAN);
		sts.scan_empty = (pend_q == '0);
		sts.scan_last  = (pend_rest == '0);
		sts.out_free   = out_free;
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_q))
		else $error("key found in more than one slot");

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q == CNT_W'($countones(ent_valid_q)))
		else $error("occupancy count out of step with valid bits");

	assert property (@(posedge clk) disable iff (!arst_n)
		(ctl.emit_op || ctl.emit_scan) |-> out_free)
		else $error("result written over an untaken word");

endmodule
`default_nettype wire

// ===== rtl/inflight_request_table.sv =====
// Flow: an accepted word is evaluated, then its result word is emitted once the output register is free.
// Insert, lookup and remove: one result; the next word is accepted only after that result
//   is emitted.
// Expiry scan: one result per cycle for each expired slot while m_tready is high,
//   paced by the single output register; input held until the last.
// Reset (arst_n, asynchronous): table empty, occupancy zero, timeout 60; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module inflight_request_table (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// s_tdata: key_type, key_hash_w0..w3, peer_in, time_now (lowest bit up)
	input  wire logic [irt_pkg::S_TDATA_W-1:0]   s_tdata,
	// s_tuser: command
	input  wire logic [1:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// m_tdata: peer_out, out_key_type, out_hash_w0..w3, occupancy, zero pad
	output logic [irt_pkg::M_TDATA_W-1:0]        m_tdata,
	// m_tuser: status
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [irt_pkg::APB_AW-1:0]      paddr,
	input  wire logic [31:0]                     pwdata,
	output logic [31:0]                          prdata,
	output logic                                 pready
);
	import irt_pkg::*;

	logic [TMO_W-1:0] timeout_q;
	logic             sel_timeout;
	ctl_t             ctl;
	sts_t             sts;

	assign pready      = 1'b1;
	assign sel_timeout = (paddr[2] == REG_TIMEOUT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TMO_RESET;
		end else if (psel && penable && pwrite && pready && sel_timeout) begin
			timeout_q <= pwdata[TMO_W-1:0];
		end
	end

	assign prdata = sel_timeout ? {16'b0, timeout_q} : 32'b0;

	irt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.ctl      (ctl)
	);

	irt_dpath u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.timeout  (timeout_q),
		.ctl      (ctl),
		.sts      (sts),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
module tb_top;
	import irt_pkg::*;

	localparam int POOL = 24;
	localparam logic [APB_AW-1:0] ADDR_TIMEOUT = {REG_TIMEOUT, 2'b00};
	localparam logic [APB_AW-1:0] ADDR_UNUSED  = 3'd4;

	typedef struct packed {
		logic [TYPE_W-1:0] ktype;
		logic [HASH_W-1:0] h3;
		logic [HASH_W-1:0] h2;
		logic [HASH_W-1:0] h1;
		logic [HASH_W-1:0] h0;
	} key_t;

	typedef struct packed {
		status_t           status;
		logic [PEER_W-1:0] peer;
		key_t              key;
		logic              last;
		logic [OCC_W-1:0]  occ;
	} result_t;

	typedef struct {
		cmd_t              cmd;
		int                key_idx;
		logic [PEER_W-1:0] peer;
		logic [TIME_W-1:0] now;
		bit                typed;
		status_t           status;
		logic [PEER_W-1:0] peer_out;
		logic [OCC_W-1:0]  occ;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// s_tdata: key_type, key_hash_w0..w3, peer_in, time_now (lowest bit up)
	logic [S_TDATA_W-1:0] s_tdata = '0;
	// s_tuser: command
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// m_tdata: peer_out, out_key_type, out_hash_w0..w3, occupancy, zero pad
	logic [M_TDATA_W-1:0] m_tdata;
	// m_tuser: status
	logic [1:0] m_tuser;
	logic m_tlast;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [APB_AW-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	// table shadow
	logic              ent_valid [ENTRIES];
	key_t              ent_key   [ENTRIES];
	logic [PEER_W-1:0] ent_peer  [ENTRIES];
	logic [TIME_W-1:0] ent_stamp [ENTRIES];
	int                occupancy;
	logic [TMO_W-1:0]  timeout_sec;

	result_t  step_res[$];
	result_t  awaited[$];
	dir_row_t rows[$];
	key_t     pool[POOL];

	int errors = 0;
	int words_sent = 0;
	int results_seen = 0;
	int expired_reported = 0;
	int full_refusals = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit pressure_armed = 1'b0;
	bit pressure_taken = 1'b0;
	int hold_left = 0;
	logic [TIME_W-1:0] clock_sec;

	inflight_request_table DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
		.prdata(prdata), .pready(pready)
	);

	always #4 clk = ~clk;

	initial begin
		#3_000_000;
		$display("** inflight_request_table: FAILED **");
		$finish;
	end

	function automatic key_t rand_key();
		key_t k;
		k.ktype = $urandom;
		k.h0 = {$urandom, $urandom};
		k.h1 = {$urandom, $urandom};
		k.h2 = {$urandom, $urandom};
		k.h3 = {$urandom, $urandom};
		return k;
	endfunction

	// compute the results of one command and update the shadow table
	function automatic void table_step(input cmd_t cmd, input key_t k,
			input logic [PEER_W-1:0] peer, input logic [TIME_W-1:0] now);
		int hit;
		int free_slot;
		logic [TIME_W-1:0] age;
		result_t r;
		step_res.delete();
		hit = -1;
		free_slot = -1;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (ent_valid[i] && ent_key[i] == k)
				hit = i;
			if (!ent_valid[i])
				free_slot = i;
		end
		r = '0;
		r.last = 1'b1;
		case (cmd)
		CMD_INSERT: begin
			if (hit >= 0) begin
				r.status = ST_MISS;
			end else if (free_slot < 0) begin
				r.status = ST_FULL;
				full_refusals++;
			end else begin
				ent_valid[free_slot] = 1'b1;
				ent_key[free_slot] = k;
				ent_peer[free_slot] = peer;
				ent_stamp[free_slot] = now;
				occupancy++;
				r.status = ST_OK;
			end
		end
		CMD_LOOKUP: begin
			r.status = (hit >= 0) ? ST_OK : ST_MISS;
			if (hit >= 0)
				r.peer = ent_peer[hit];
		end
		CMD_REMOVE: begin
			r.status = (hit >= 0) ? ST_OK : ST_MISS;
			if (hit >= 0) begin
				r.peer = ent_peer[hit];
				ent_valid[hit] = 1'b0;
				occupancy--;
			end
		end
		default: begin
			for (int i = 0; i < ENTRIES; i++) begin
				age = now - ent_stamp[i];
				if (ent_valid[i] && age >= {16'h0, timeout_sec}) begin
					r.status = ST_OK;
					r.peer = ent_peer[i];
					r.key = ent_key[i];
					r.last = 1'b0;
					r.occ = OCC_W'(occupancy);
					step_res = {step_res, r};
				end
			end
			expired_reported += step_res.size();
			r = '0;
			r.status = ST_NONE;
			r.last = 1'b1;
			if (step_res.size() != 0) begin
				r = step_res.pop_back();
				r.last = 1'b1;
			end
		end
		endcase
		r.occ = OCC_W'(occupancy);
		step_res = {step_res, r};
	endfunction

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
			errors++;
		end
	endtask

	// receiver: random stalls, plus one long hold-off when armed
	always @(posedge clk) begin
		if (pressure_armed && !pressure_taken) begin
			hold_left = 400;
			pressure_taken = 1'b1;
		end
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (awaited.size() == 0) begin
				$display("%0t: unexpected result word, status %0d tdata %h", $time, m_tuser,
					m_tdata);
				errors++;
			end else begin
				want = awaited.pop_front();
				check_field("status", 64'(want.status), 64'(m_tuser));
				check_field("peer_out", 64'(want.peer), 64'(m_tdata[15:0]));
				check_field("out_key_type", 64'(want.key.ktype), 64'(m_tdata[47:16]));
				check_field("out_hash_w0", want.key.h0, m_tdata[111:48]);
				check_field("out_hash_w1", want.key.h1, m_tdata[175:112]);
				check_field("out_hash_w2", want.key.h2, m_tdata[239:176]);
				check_field("out_hash_w3", want.key.h3, m_tdata[303:240]);
				check_field("is_last", 64'(want.last), 64'(m_tlast));
				check_field("occupancy", 64'(want.occ), 64'(m_tdata[308:304]));
			end
		end
	end

	task automatic apb_access(input logic wr, input logic [APB_AW-1:0] addr,
			input logic [31:0] data, output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_timeout(input logic [TMO_W-1:0] val);
		logic [31:0] rd;
		logic [15:0] junk;
		junk = 16'($urandom);
		// upper bits are dropped by the register
		apb_access(1'b1, ADDR_TIMEOUT, {junk, val}, rd);
		timeout_sec = val;
		apb_access(1'b1, ADDR_UNUSED, $urandom, rd);
		apb_access(1'b0, ADDR_TIMEOUT, 32'h0, rd);
		check_field("timeout readback", 64'({16'h0, timeout_sec}), 64'(rd));
	endtask

	task automatic send_word(input cmd_t cmd, input key_t k, input logic [PEER_W-1:0] peer,
			input logic [TIME_W-1:0] now, input bit typed, input result_t want);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= {now, peer, k.h3, k.h2, k.h1, k.h0, k.ktype};
		do @(posedge clk); while (!s_tready);
		words_sent++;
		table_step(cmd, k, peer, now);
		if (typed)
			awaited = {awaited, want};
		else
			foreach (step_res[i])
				awaited = {awaited, step_res[i]};
	endtask

	task automatic drain(input int tail);
		s_tvalid <= 1'b0;
		while (awaited.size() != 0)
			@(posedge clk);
		repeat (tail) @(posedge clk);
	endtask

	task automatic add_row(input cmd_t c, input int ki, input logic [PEER_W-1:0] p,
			input logic [TIME_W-1:0] t, input bit typed, input status_t st,
			input logic [PEER_W-1:0] po, input logic [OCC_W-1:0] occ);
		dir_row_t row;
		row.cmd = c;
		row.key_idx = ki;
		row.peer = p;
		row.now = t;
		row.typed = typed;
		row.status = st;
		row.peer_out = po;
		row.occ = occ;
		rows = {rows, row};
	endtask

	task automatic random_phase(input logic [TMO_W-1:0] tmo, input int s_pct, input int r_pct,
			input int count, input bit pressure);
		int r;
		cmd_t c;
		key_t k;
		drain(8);
		set_timeout(tmo);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		if (pressure)
			pressure_armed = 1'b1;
		for (int n = 0; n < count; n++) begin
			r = $urandom_range(0, 99);
			c = (r < 35) ? CMD_INSERT : (r < 55) ? CMD_LOOKUP : (r < 85) ? CMD_REMOVE : CMD_SCAN;
			r = $urandom_range(0, 99);
			k = pool[$urandom_range(0, POOL - 1)];
			if (r >= 90)
				k = rand_key();
			else if (r >= 80)
				k ^= (288'b1 << $urandom_range(0, 287));
			r = $urandom_range(0, 99);
			if (r < 8)
				clock_sec = $urandom;
			else if (r < 18)
				clock_sec += $urandom_range(0, 131072);
			else
				clock_sec += $urandom_range(0, 40);
			send_word(c, k, PEER_W'($urandom), clock_sec, 1'b0, '0);
		end
	endtask

	initial begin
		result_t want;
		logic [31:0] rd;
		for (int i = 0; i < ENTRIES; i++)
			ent_valid[i] = 1'b0;
		occupancy = 0;
		timeout_sec = TMO_RESET;
		clock_sec = $urandom;
		for (int i = 0; i < POOL; i++)
			pool[i] = rand_key();
		pool[0] = '0;
		pool[1] = '1;
		pool[2] = '1;
		pool[2].h3[0] = 1'b0;

		add_row(CMD_SCAN, 0, 16'h0, 32'd1000, 1'b1, ST_NONE, 16'h0, 5'd0);
		add_row(CMD_LOOKUP, 0, 16'h0, 32'd0, 1'b1, ST_MISS, 16'h0, 5'd0);
		add_row(CMD_REMOVE, 0, 16'h0, 32'd0, 1'b1, ST_MISS, 16'h0, 5'd0);
		add_row(CMD_INSERT, 0, 16'h0, 32'd0, 1'b1, ST_OK, 16'h0, 5'd1);
		add_row(CMD_INSERT, 0, 16'h1234, 32'd5, 1'b1, ST_MISS, 16'h0, 5'd1);
		add_row(CMD_INSERT, 1, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, ST_OK, 16'h0, 5'd2);
		add_row(CMD_LOOKUP, 2, 16'h0, 32'd0, 1'b1, ST_MISS, 16'h0, 5'd2);
		add_row(CMD_LOOKUP, 1, 16'h0, 32'd0, 1'b1, ST_OK, 16'hFFFF, 5'd2);
		// stamp near the top of the range: age wraps to exactly the timeout
		add_row(CMD_SCAN, 0, 16'h0, 32'd59, 1'b0, ST_OK, 16'h0, 5'd0);
		add_row(CMD_INSERT, 2, 16'hA5A5, 32'd100, 1'b1, ST_OK, 16'h0, 5'd3);
		for (int i = 3; i < ENTRIES; i++)
			add_row(CMD_INSERT, i, PEER_W'($urandom), TIME_W'(100 + i), 1'b1, ST_OK, 16'h0,
				OCC_W'(i + 1));
		add_row(CMD_INSERT, ENTRIES, 16'h0F0F, 32'd200, 1'b1, ST_FULL, 16'h0, 5'd16);
		add_row(CMD_REMOVE, 0, 16'h0, 32'd0, 1'b1, ST_OK, 16'h0, 5'd15);
		add_row(CMD_INSERT, 0, 16'h8001, 32'd300, 1'b1, ST_OK, 16'h0, 5'd16);
		add_row(CMD_SCAN, 0, 16'h0, 32'h8000_0000, 1'b0, ST_OK, 16'h0, 5'd0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_access(1'b0, ADDR_TIMEOUT, 32'h0, rd);
		check_field("timeout after reset", 64'({16'h0, TMO_RESET}), 64'(rd));

		send_idle_pct = 35;
		recv_idle_pct = 63;
		foreach (rows[i]) begin
			want = '0;
			want.status = rows[i].status;
			want.peer = rows[i].peer_out;
			want.last = 1'b1;
			want.occ = rows[i].occ;
			send_word(rows[i].cmd, pool[rows[i].key_idx], rows[i].peer, rows[i].now,
				rows[i].typed, want);
		end

		random_phase(16'd0, 35, 63, 18, 1'b0);
		random_phase(16'hFFFF, 63, 35, 18, 1'b0);
		random_phase(TMO_W'($urandom_range(1, 200)), 0, 0, 18, 1'b0);
		random_phase(TMO_W'($urandom_range(1, 100)), 0, 0, 18, 1'b1);
		drain(30);

		$display("Covered %0d command words and %0d result words across five timeout settings,",
			words_sent, results_seen);
		$display("with %0d expired entries reported and %0d inserts refused on a full table.",
			expired_reported, full_refusals);
		if (errors == 0)
			$display("** inflight_request_table: PASSED **");
		else
			$display("** inflight_request_table: FAILED **");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/irt_pkg.sv
rtl/irt_ctrl.sv
rtl/irt_dpath.sv
rtl/inflight_request_table.sv
sim/tb_top.sv
